>>> src/sfe_pkg.sv
// Shared types and constants for the stuffed frame encoder.
`timescale 1ns / 1ps

package sfe_pkg;

  // Record and byte geometry.
  localparam int unsigned ByteW       = 8;
  localparam int unsigned RecordBytes = 7;
  localparam int unsigned CntW        = $clog2(RecordBytes);
  localparam int unsigned CfgIdxW     = 2;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] StartMarkerRst  = 8'd2;
  localparam logic [ByteW-1:0] StopMarkerRst   = 8'd3;
  localparam logic [ByteW-1:0] EscapeByteRst   = 8'd10;
  localparam logic [ByteW-1:0] EscapeOffsetRst = 8'd20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER  = 2'd0,
    CFG_STOP_MARKER   = 2'd1,
    CFG_ESCAPE_BYTE   = 2'd2,
    CFG_ESCAPE_OFFSET = 2'd3
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_DATA_MASK,
    ST_SUM,
    ST_SUM_MASK,
    ST_STOP
  } state_e;

  // Source of the byte loaded into the output register.
  typedef enum logic [2:0] {
    SEL_START,
    SEL_DATA,
    SEL_ESCAPE,
    SEL_DATA_MASK,
    SEL_SUM,
    SEL_SUM_MASK,
    SEL_STOP
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     emit;
    out_sel_e sel;
    logic     add_sum;
    logic     next_byte;
    logic     last;
  } sfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic data_rsv;
    logic sum_rsv;
    logic last_byte;
  } sfe_stat_t;

endpackage

>>> src/sfe_ctrl.sv
// Controller state machine that sequences the bytes of one frame.
`timescale 1ns / 1ps

module sfe_ctrl import sfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sfe_stat_t stat_i,
  output sfe_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        if (stat_i.out_free) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (stat_i.out_free) begin
          if (stat_i.data_rsv) state_d = ST_DATA_MASK;
          else if (stat_i.last_byte) state_d = ST_SUM;
        end
      end
      ST_DATA_MASK: begin
        if (stat_i.out_free) state_d = stat_i.last_byte ? ST_SUM : ST_DATA;
      end
      ST_SUM: begin
        if (stat_i.out_free) state_d = stat_i.sum_rsv ? ST_SUM_MASK : ST_STOP;
      end
      ST_SUM_MASK: begin
        if (stat_i.out_free) state_d = ST_STOP;
      end
      ST_STOP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_START;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_START: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_START;
      end
      ST_DATA: begin
        cmd_o.emit    = stat_i.out_free;
        cmd_o.add_sum = stat_i.out_free;
        if (stat_i.data_rsv) begin
          cmd_o.sel = SEL_ESCAPE;
        end else begin
          cmd_o.sel       = SEL_DATA;
          cmd_o.next_byte = stat_i.out_free;
        end
      end
      ST_DATA_MASK: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.add_sum   = stat_i.out_free;
        cmd_o.next_byte = stat_i.out_free;
        cmd_o.sel       = SEL_DATA_MASK;
      end
      ST_SUM: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = stat_i.sum_rsv ? SEL_ESCAPE : SEL_SUM;
      end
      ST_SUM_MASK: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_SUM_MASK;
      end
      ST_STOP: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_STOP;
        cmd_o.last = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> src/sfe_dp.sv
// Datapath: configuration registers, record shift line, checksum and output register.
`timescale 1ns / 1ps

module sfe_dp import sfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic [ByteW-1:0]   rec_i [RecordBytes],
  input  sfe_cmd_t           cmd_i,
  output sfe_stat_t          stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               frame_end_o
);

  logic [ByteW-1:0] start_q, stop_q, esc_q, ofs_q;
  logic [ByteW-1:0] rec_q [RecordBytes];
  logic [CntW-1:0]  cnt_q;
  logic [ByteW-1:0] sum_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             frame_end_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartMarkerRst;
      stop_q  <= StopMarkerRst;
      esc_q   <= EscapeByteRst;
      ofs_q   <= EscapeOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_MARKER:  start_q <= cfg_data_i;
        CFG_STOP_MARKER:   stop_q  <= cfg_data_i;
        CFG_ESCAPE_BYTE:   esc_q   <= cfg_data_i;
        CFG_ESCAPE_OFFSET: ofs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Record shift line; the byte being sent always sits in entry zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < RecordBytes; i++) rec_q[i] <= rec_i[i];
    end else if (cmd_i.next_byte) begin
      for (int i = 0; i < RecordBytes - 1; i++) rec_q[i] <= rec_q[i+1];
    end
  end

  // Byte counter and running checksum over the stuffed payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      if (cmd_i.next_byte) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.add_sum) sum_q <= sum_q + out_byte_d;
    end
  end

  // Output byte selection.
  always_comb begin
    case (cmd_i.sel)
      SEL_START:     out_byte_d = start_q;
      SEL_DATA:      out_byte_d = rec_q[0];
      SEL_ESCAPE:    out_byte_d = esc_q;
      SEL_DATA_MASK: out_byte_d = rec_q[0] + ofs_q;
      SEL_SUM:       out_byte_d = sum_q;
      SEL_SUM_MASK:  out_byte_d = sum_q + ofs_q;
      SEL_STOP:      out_byte_d = stop_q;
      default:       out_byte_d = start_q;
    endcase
  end

  // Output register; it takes a new byte once the previous transaction is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q  <= out_byte_d;
      frame_end_q <= cmd_i.last;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.out_free  = !out_valid_q || !out_stall_i;
    stat_o.data_rsv  = (rec_q[0] == start_q) || (rec_q[0] == stop_q) || (rec_q[0] == esc_q);
    stat_o.sum_rsv   = (sum_q == start_q) || (sum_q == stop_q) || (sum_q == esc_q);
    stat_o.last_byte = (cnt_q == CntW'(RecordBytes - 1));
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

endmodule

>>> src/stuffed_frame_encoder.sv
// Top level of the stuffed frame encoder.
`timescale 1ns / 1ps

// Takes one seven-byte record per transaction and sends it as a stuffed frame, one byte
// per output transaction: start marker, record bytes with reserved values escaped, an
// additive checksum over the sent payload bytes (escaped if reserved), and the stop
// marker, which carries frame_end. A frame is 10 to 18 bytes. The output register takes
// one byte per cycle while out_stall_i is low, and the record is taken in the idle state
// before the start marker is sent. The next record is taken once the stop marker has
// been loaded into that register. Configuration writes are taken at any time but belong
// to idle periods.

module stuffed_frame_encoder import sfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   device_id_i,
  input  logic [ByteW-1:0]   count_high_i,
  input  logic [ByteW-1:0]   count_low_i,
  input  logic [ByteW-1:0]   card_byte_0_i,
  input  logic [ByteW-1:0]   card_byte_1_i,
  input  logic [ByteW-1:0]   card_byte_2_i,
  input  logic [ByteW-1:0]   card_byte_3_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               frame_end_o
);

  sfe_cmd_t         cmd;
  sfe_stat_t        stat;
  logic [ByteW-1:0] rec [RecordBytes];

  // Record bytes in transmission order.
  assign rec[0] = device_id_i;
  assign rec[1] = count_high_i;
  assign rec[2] = count_low_i;
  assign rec[3] = card_byte_0_i;
  assign rec[4] = card_byte_1_i;
  assign rec[5] = card_byte_2_i;
  assign rec[6] = card_byte_3_i;

  sfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rec_i       (rec),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule
